// ===== rtl/multistate_cellular_automaton_step_assert.svh =====
// Assertion macros for the cellular automaton step block
`ifndef MULTISTATE_CELLULAR_AUTOMATON_STEP_ASSERT_SVH
`define MULTISTATE_CELLULAR_AUTOMATON_STEP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define MCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/mca_pkg.sv =====
// Package: types and constants of the cellular automaton step block
package mca_pkg;
	localparam int ReqW = 2;
	localparam int CoordW = 6;
	localparam int ColorW = 4;
	localparam int RuleW = 24;
	localparam int NumRuleRegs = 8;
	localparam int CfgIdxW = 3;

	localparam logic [ReqW-1:0] REQ_WRITE = 2'd0;
	localparam logic [ReqW-1:0] REQ_READ = 2'd1;
	localparam logic [ReqW-1:0] REQ_GEN = 2'd2;
	localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [ReqW-1:0] req_type;
		logic [CoordW-1:0] row;
		logic [CoordW-1:0] col;
		logic [ColorW-1:0] cell_value;
	} req_t;

	typedef struct packed {
		logic [ColorW-1:0] read_value;
		logic done_res;
	} rsp_t;

	typedef struct packed {
		logic valid;
		logic [ColorW-1:0] new_col;
		logic negate;
		logic [8:0] mask;
		logic uncond;
		logic [ColorW-1:0] nb_col;
		logic [ColorW-1:0] cell_col;
	} rule_t;
endpackage

// ===== rtl/mca_stream_if.sv =====
// Valid/ready channel interface
interface mca_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/multistate_cellular_automaton_step.sv =====
// Top level: cellular automaton grid with write, read and generation requests
//
// channel | dir | payload
// req     | in  | req_type, row, col, cell_value
// rsp     | out | read_value, done_res
//
// A write is done in ST_IDLE; a read passes through ST_RD to fetch the cell.
// After reset a clearing pass (ST_CLEAR) zeroes the whole grid.
// A generation copies grid to snapshot, then sweeps the cells one by one
// (9 snapshot reads, one per cycle, then evaluate and write-back), a pace
// set by the single snapshot read port.
// The response register holds while rsp is stalled; no new item is taken then.
`include "multistate_cellular_automaton_step_assert.svh"
module multistate_cellular_automaton_step #(
	parameter int GRID_SIZE = 64,
	parameter int RULE_COUNT = 8
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mca_pkg::CfgIdxW-1:0] cfg_index,
	input logic [mca_pkg::RuleW-1:0] cfg_data,
	mca_stream_if.sink req,
	mca_stream_if.source rsp
);
	import mca_pkg::*;

	localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);
	localparam int GW = $clog2(GRID_SIZE);
	localparam int Cells = GRID_SIZE * GRID_SIZE;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_RD = 8'b0000_0100,
		ST_COPY = 8'b0000_1000,
		ST_NB = 8'b0001_0000,
		ST_EVAL = 8'b0010_0000,
		ST_RESP = 8'b0100_0000,
		ST_WB = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [RuleW-1:0] rule_q [NumRuleRegs];
	logic [AW:0] addr_q;      // sweep / cell counter
	logic [GW-1:0] cr_q, cc_q; // row / column of the swept cell
	logic [3:0] nb_q;         // neighbor step 0..9 (0: centre)
	logic [3:0] nbp_s1;       // step whose read is in flight
	logic nbv_s1;
	logic [ColorW-1:0] here_q;
	logic [ColorW-1:0] nbc_q [8];
	logic [ColorW-1:0] rd_q;
	logic rsp_v_q;

	logic [ColorW-1:0] grid_mem [Cells];
	logic [ColorW-1:0] snap_mem [Cells];
	logic g_we, s_we;
	logic [AW-1:0] g_wa, g_ra, s_ra;
	logic [ColorW-1:0] g_wd, g_rd_q, s_rd_q;

	always_ff @(posedge clk) begin
		if (g_we) grid_mem[g_wa] <= g_wd;
		g_rd_q <= grid_mem[g_ra];
	end
	always_ff @(posedge clk) begin
		if (s_we) snap_mem[addr_q[AW-1:0] - AW'(1)] <= g_rd_q;
		s_rd_q <= snap_mem[s_ra];
	end

	logic [GW-1:0] cr, cc, nr, nc;
	logic in_grid;
	assign cr = cr_q;
	assign cc = cc_q;
	assign in_grid = (32'(req.payload.row) < GRID_SIZE) && (32'(req.payload.col) < GRID_SIZE);

	function automatic logic [GW-1:0] wrap(input logic [GW-1:0] v, input logic [1:0] d);
		logic [GW-1:0] r;
		r = v;
		if (d == 2'd0) r = (v == '0) ? GW'(GRID_SIZE - 1) : v - GW'(1);
		else if (d == 2'd2) r = (32'(v) == GRID_SIZE - 1) ? '0 : v + GW'(1);
		return r;
	endfunction

	// neighbor offset for step k: 0 centre, 1..8 ring
	always_comb begin
		logic [1:0] dr, dc;
		dr = 2'd1; dc = 2'd1;
		case (nb_q)
			4'd1: begin dr = 2'd0; dc = 2'd0; end
			4'd2: begin dr = 2'd0; dc = 2'd1; end
			4'd3: begin dr = 2'd0; dc = 2'd2; end
			4'd4: begin dr = 2'd1; dc = 2'd0; end
			4'd5: begin dr = 2'd1; dc = 2'd2; end
			4'd6: begin dr = 2'd2; dc = 2'd0; end
			4'd7: begin dr = 2'd2; dc = 2'd1; end
			4'd8: begin dr = 2'd2; dc = 2'd2; end
			default: ;
		endcase
		nr = wrap(cr, dr);
		nc = wrap(cc, dc);
	end
	assign s_ra = AW'(32'(nr) * GRID_SIZE + 32'(nc));

	// rule evaluation on the gathered neighborhood
	logic hit;
	logic [ColorW-1:0] new_col;
	always_comb begin
		rule_t r;
		logic [3:0] n;
		hit = 1'b0;
		new_col = here_q;
		for (int k = NumRuleRegs - 1; k >= 0; k--) begin
			r = rule_t'(rule_q[k]);
			n = '0;
			for (int j = 0; j < 8; j++) n = n + 4'(nbc_q[j] == r.nb_col);
			if (k < RULE_COUNT && r.valid && r.cell_col == here_q &&
			    (r.uncond || (r.mask[n] != r.negate))) begin
				hit = 1'b1;
				new_col = r.new_col;
			end
		end
	end

	always_comb begin
		g_we = 1'b0; g_wa = addr_q[AW-1:0]; g_wd = '0;
		g_ra = addr_q[AW-1:0];
		s_we = 1'b0;
		unique case (state_q)
			ST_CLEAR: g_we = 1'b1;
			ST_IDLE: begin
				g_ra = AW'(32'(req.payload.row) * GRID_SIZE + 32'(req.payload.col));
				g_wa = g_ra;
				g_wd = req.payload.cell_value;
				g_we = req.valid && !rsp_v_q && req.payload.req_type == REQ_WRITE && in_grid;
			end
			ST_COPY: s_we = addr_q != '0;
			ST_WB: begin g_we = hit; g_wd = new_col; end
			default: ;
		endcase
	end

	assign req.ready = state_q == ST_IDLE && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.payload = '{read_value: rd_q, done_res: 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRuleRegs; i++) rule_q[i] <= '0;
		end else if (cfg_we) begin
			rule_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR; addr_q <= '0; nb_q <= '0; nbv_s1 <= 1'b0;
			nbp_s1 <= '0; rsp_v_q <= 1'b0; rd_q <= '0; here_q <= '0;
			cr_q <= '0; cc_q <= '0;
			for (int j = 0; j < 8; j++) nbc_q[j] <= '0;
		end else begin
			if (rsp.valid && rsp.ready) rsp_v_q <= 1'b0;
			nbv_s1 <= (state_q == ST_NB);
			if (nbv_s1) begin
				if (nbp_s1 == 4'd0) here_q <= s_rd_q;
				else nbc_q[3'(nbp_s1 - 4'd1)] <= s_rd_q;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (32'(addr_q) == Cells - 1) begin
						addr_q <= '0; state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: if (req.valid && !rsp_v_q) begin
					rd_q <= '0;
					case (req.payload.req_type)
						REQ_READ: if (in_grid) state_q <= ST_RD;
						REQ_GEN: begin addr_q <= '0; state_q <= ST_COPY; end
						default: ;
					endcase
					if (!(req.payload.req_type == REQ_GEN) &&
					    !(req.payload.req_type == REQ_READ && in_grid)) rsp_v_q <= 1'b1;
				end
				ST_RD: begin rd_q <= g_rd_q; rsp_v_q <= 1'b1; state_q <= ST_IDLE; end
				ST_COPY: begin
					if (32'(addr_q) == Cells) begin
						addr_q <= '0; nb_q <= '0; cr_q <= '0; cc_q <= '0;
						state_q <= ST_NB;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_NB: begin
					nbp_s1 <= nb_q; nb_q <= nb_q + 4'd1;
					if (nb_q == 4'd8) state_q <= ST_EVAL;
				end
				ST_EVAL: state_q <= ST_WB;   // last neighbor lands
				ST_WB: begin
					nb_q <= '0;
					addr_q <= addr_q + 1'b1;
					if (32'(cc_q) == GRID_SIZE - 1) begin
						cc_q <= '0;
						cr_q <= cr_q + GW'(1);
					end else begin
						cc_q <= cc_q + GW'(1);
					end
					state_q <= (32'(addr_q) == Cells - 1) ? ST_RESP : ST_NB;
				end
				ST_RESP: begin rsp_v_q <= 1'b1; addr_q <= '0; state_q <= ST_IDLE; end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MCA_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !req.ready)
	`MCA_ASSERT_IMP(a_ready_vs_rsp, clk, arst_n, rsp_v_q, !req.ready)
	`MCA_ASSERT_NEXT(a_rd_resp, clk, arst_n, state_q == ST_RD, rsp_v_q && state_q == ST_IDLE)
	`MCA_ASSERT_IMP(a_wb_nb_done, clk, arst_n, state_q == ST_WB, nb_q == 4'd9)
endmodule

// ===== tb/tb.sv =====
// Testbench for multistate_cellular_automaton_step: self-checking, scoreboard-based
`timescale 1ns / 100ps
module tb;
	import mca_pkg::*;

	localparam int N = 64;
	localparam int CELLS = N * N;
	localparam int HoldCycles = 400;

	typedef enum {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [RuleW-1:0] cfg_data;

	mca_stream_if #(.T(req_t)) req_ch ();
	mca_stream_if #(.T(rsp_t)) rsp_ch ();

	multistate_cellular_automaton_step i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	// Shadow copy of the block: colors, snapshot and rule words
	logic [ColorW-1:0] grid_colors [CELLS];
	logic [ColorW-1:0] snap_colors [CELLS];
	rule_t rule_words [NumRuleRegs];

	req_t pending_reqs [$];      // items waiting for the driver
	rsp_t expected_rsps [$];     // responses still owed by the block
	flow_t flow;
	logic hold_go;               // asks for one long receiver hold-off
	logic hold_rsp;              // long receiver hold-off for back-pressure
	int hold_cnt;
	int errors;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Number of wrapped Moore neighbours of (r,c) in the snapshot with the given color
	function automatic int neighbours_of_color(int r, int c, logic [ColorW-1:0] color);
		int total;
		total = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				if (dr != 0 || dc != 0) begin
					if (snap_colors[((r + dr + N) % N) * N + ((c + dc + N) % N)] == color)
						total++;
				end
			end
		end
		return total;
	endfunction

	// One generation: first valid rule whose cell color and count condition hold wins
	task automatic evolve_grid();
		logic [ColorW-1:0] here;
		logic hit;
		int cnt;
		for (int i = 0; i < CELLS; i++)
			snap_colors[i] = grid_colors[i];
		for (int r = 0; r < N; r++) begin
			for (int c = 0; c < N; c++) begin
				here = snap_colors[r * N + c];
				for (int k = 0; k < NumRuleRegs; k++) begin
					if (rule_words[k].valid && rule_words[k].cell_col == here) begin
						if (rule_words[k].uncond) begin
							hit = 1'b1;
						end else begin
							cnt = neighbours_of_color(r, c, rule_words[k].nb_col);
							hit = rule_words[k].mask[cnt] ^ rule_words[k].negate;
						end
						if (hit) begin
							grid_colors[r * N + c] = rule_words[k].new_col;
							break;
						end
					end
				end
			end
		end
	endtask

	// Apply a request to the shadow grid and return the response it must produce
	task automatic apply_request(input req_t rq, output rsp_t rs);
		rs.read_value = '0;
		rs.done_res = 1'b1;
		case (rq.req_type)
			REQ_WRITE: begin
				grid_colors[rq.row * N + rq.col] = rq.cell_value;
			end
			REQ_READ: begin
				rs.read_value = grid_colors[rq.row * N + rq.col];
			end
			REQ_GEN: begin
				evolve_grid();
			end
			default: begin
				// unused code: nothing changes
			end
		endcase
	endtask

	// Driver: a valid item stays up until taken; new items are predicted when offered
	always @(posedge clk or negedge arst_n) begin
		req_t rq;
		rsp_t rs;
		logic idle;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.payload <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			idle = (flow == FLOW_SEND_IDLE && $urandom_range(0, 99) < 80) ||
				(flow == FLOW_BOTH && $urandom_range(0, 99) < 37);
			if (pending_reqs.size() != 0 && !idle) begin
				rq = pending_reqs.pop_front();
				apply_request(rq, rs);
				expected_rsps = {expected_rsps, rs};
				req_ch.payload <= rq;
				req_ch.valid <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here once the main sequence asks for it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_rsp <= 1'b0;
		end else if (hold_go && hold_cnt < HoldCycles) begin
			hold_cnt <= hold_cnt + 1;
			hold_rsp <= 1'b1;
		end else begin
			hold_rsp <= 1'b0;
		end
	end

	// Receiver ready: random stalls per flow mode, forced low during a hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else if (hold_rsp)
			rsp_ch.ready <= 1'b0;
		else if (flow == FLOW_RECV_STALL)
			rsp_ch.ready <= ($urandom_range(0, 99) >= 80);
		else if (flow == FLOW_BOTH)
			rsp_ch.ready <= ($urandom_range(0, 99) >= 37);
		else
			rsp_ch.ready <= 1'b1;
	end

	// Monitor: every accepted response against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected response read_value=%0d done_res=%0d",
					rsp_ch.payload.read_value, rsp_ch.payload.done_res);
				errors++;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp_ch.payload.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d",
						want.read_value, rsp_ch.payload.read_value);
					errors++;
				end
				if (rsp_ch.payload.done_res !== want.done_res) begin
					$error("done_res: expected %0d, got %0d",
						want.done_res, rsp_ch.payload.done_res);
					errors++;
				end
			end
		end
	end

	task automatic write_rule(int idx, logic [RuleW-1:0] word);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx[CfgIdxW-1:0];
		cfg_data <= word;
		rule_words[idx] = word;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Build a rule word from its fields
	function automatic logic [RuleW-1:0] make_rule(logic v, logic [3:0] cell_c,
			logic [3:0] nb, logic unc, logic [8:0] mask, logic neg, logic [3:0] nc);
		rule_t w;
		w.valid = v;
		w.cell_col = cell_c;
		w.nb_col = nb;
		w.uncond = unc;
		w.mask = mask;
		w.negate = neg;
		w.new_col = nc;
		return w;
	endfunction

	// Random rule: biased toward low colors so rules actually fire on the grid
	function automatic logic [RuleW-1:0] random_rule();
		return make_rule($urandom_range(0, 9) != 0, 4'($urandom_range(0, 3)),
			4'($urandom_range(0, 3)), $urandom_range(0, 5) == 0, 9'($urandom),
			1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
	endfunction

	function automatic req_t mk_req(logic [1:0] kind, int r, int c, int v);
		req_t rq;
		rq.req_type = kind;
		rq.row = r[CoordW-1:0];
		rq.col = c[CoordW-1:0];
		rq.cell_value = v[ColorW-1:0];
		return rq;
	endfunction

	// Append an item to the driver's queue
	task automatic queue_req(req_t rq);
		pending_reqs = {pending_reqs, rq};
	endtask

	// Coordinate mostly in a small patch that straddles the wrap, sometimes anywhere
	function automatic int pick_coord();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, N - 1);
		return ($urandom_range(0, 9) + N - 4) % N;
	endfunction

	// Block is quiet: nothing queued, nothing owed, plus a margin for the last write
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_ch.valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_phase(flow_t mode, int items, int gens);
		int kind;
		flow = mode;
		for (int i = 0; i < items; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 60)
				queue_req(mk_req(REQ_WRITE, pick_coord(), pick_coord(),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3)));
			else if (kind < 97)
				queue_req(mk_req(REQ_READ, pick_coord(), pick_coord(), $urandom));
			else
				queue_req(mk_req(REQ_UNUSED, $urandom, $urandom, $urandom));
			// generations spread through the phase, followed by reads of the patch
			if (gens > 0 && i % (items / gens) == items / gens - 1) begin
				queue_req(mk_req(REQ_GEN, $urandom, $urandom, $urandom));
				repeat (4)
					queue_req(mk_req(REQ_READ, pick_coord(), pick_coord(), 0));
			end
		end
		wait_drained();
	endtask

	initial begin
		errors = 0;
		flow = FLOW_FREE;
		hold_go = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < CELLS; i++) begin
			grid_colors[i] = '0;
			snap_colors[i] = '0;
		end
		for (int k = 0; k < NumRuleRegs; k++)
			rule_words[k] = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Rule set: counted birth, negated survival, unconditional recolor, wide words
		write_rule(0, make_rule(1, 0, 1, 0, 9'b000001000, 0, 1));
		write_rule(1, make_rule(1, 1, 1, 0, 9'b000001100, 1, 0));
		write_rule(2, make_rule(1, 15, 3, 1, 9'h000, 0, 2));
		write_rule(3, make_rule(1, 2, 2, 0, 9'b111111110, 0, 15));
		write_rule(4, make_rule(0, 0, 0, 1, 9'h1ff, 0, 7));
		write_rule(5, '1);
		write_rule(6, '0);
		write_rule(7, make_rule(1, 1, 0, 0, 9'b100000000, 0, 9));

		// Directed: corners, extreme colors, unused code, color-1 cells in row 0 across the wrap
		queue_req(mk_req(REQ_READ, 5, 5, 0));
		queue_req(mk_req(REQ_WRITE, 0, 0, 15));
		queue_req(mk_req(REQ_WRITE, 63, 63, 15));
		queue_req(mk_req(REQ_WRITE, 63, 0, 2));
		queue_req(mk_req(REQ_WRITE, 0, 62, 1));
		queue_req(mk_req(REQ_WRITE, 0, 63, 1));
		queue_req(mk_req(REQ_WRITE, 0, 1, 1));
		queue_req(mk_req(REQ_READ, 0, 0, 15));
		queue_req(mk_req(REQ_READ, 63, 63, 0));
		queue_req(mk_req(REQ_WRITE, 42, 21, 10));
		queue_req(mk_req(REQ_READ, 42, 21, 5));
		queue_req(mk_req(REQ_UNUSED, 63, 63, 15));
		queue_req(mk_req(REQ_READ, 63, 63, 0));
		queue_req(mk_req(REQ_GEN, 0, 0, 0));
		queue_req(mk_req(REQ_READ, 0, 0, 0));
		queue_req(mk_req(REQ_READ, 63, 0, 0));
		queue_req(mk_req(REQ_READ, 1, 63, 0));
		queue_req(mk_req(REQ_READ, 63, 63, 0));
		queue_req(mk_req(REQ_READ, 0, 1, 0));
		queue_req(mk_req(REQ_GEN, 63, 63, 15));
		queue_req(mk_req(REQ_READ, 0, 63, 0));
		queue_req(mk_req(REQ_READ, 1, 0, 0));
		queue_req(mk_req(REQ_READ, 42, 21, 0));
		wait_drained();

		// Random phases, each with a fresh rule set
		for (int k = 0; k < NumRuleRegs; k++)
			write_rule(k, random_rule());
		random_phase(FLOW_FREE, 22, 1);

		for (int k = 0; k < NumRuleRegs; k++)
			write_rule(k, random_rule());
		random_phase(FLOW_SEND_IDLE, 22, 1);

		// All-ones words in rules 1..7: valid, unconditional, color 15 stays 15
		for (int k = 0; k < NumRuleRegs; k++)
			write_rule(k, (k == 0) ? random_rule() : '1);
		random_phase(FLOW_RECV_STALL, 22, 1);

		for (int k = 0; k < NumRuleRegs; k++)
			write_rule(k, random_rule());
		// Back-pressure: receiver holds off while the sender keeps offering items
		flow = FLOW_FREE;
		hold_go = 1'b1;
		for (int i = 0; i < 12; i++)
			queue_req(mk_req(REQ_WRITE, pick_coord(), pick_coord(), $urandom));
		wait (hold_cnt == HoldCycles);
		hold_go = 1'b0;
		random_phase(FLOW_BOTH, 22, 1);

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("multistate_cellular_automaton_step test passed");
		else
			$display("multistate_cellular_automaton_step test failed");
		$finish;
	end

	// Run limit: several times the slowest expected run
	initial begin
		#16000000;
		$display("multistate_cellular_automaton_step test failed");
		$finish;
	end
endmodule
